FILE: src/iqfd_pkg.sv
// ----------------------------------------------------------------------------
// iqfd_pkg
// Shared constants, arctangent table and item types for the I/Q frequency
// discriminator.
// ----------------------------------------------------------------------------
package iqfd_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int PHASE_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int RATE_BITS  = 24;
    localparam int POWER_BITS = 32;
    localparam int FREQ_BITS  = 24;

    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(48000);

    // datapath widths
    localparam int GUARD_BITS = 8;
    localparam int XY_W       = SAMPLE_BITS + GUARD_BITS + 3;
    localparam int Z_W        = 32;
    localparam int SQ_W       = 2 * SAMPLE_BITS;
    localparam int SUM_W      = (SQ_W + 1 > POWER_BITS + 1) ? SQ_W + 1 : POWER_BITS + 1;
    localparam int PROD_W     = PHASE_BITS + RATE_BITS + 1;

    // rotation schedule
    localparam int ATAN_LEN        = 24;
    localparam int ITERS           = (CORDIC_STAGES > ATAN_LEN) ? ATAN_LEN : CORDIC_STAGES;
    localparam int ITERS_PER_STAGE = 4;
    localparam int CORDIC_PIPE     = (ITERS + ITERS_PER_STAGE - 1) / ITERS_PER_STAGE;

    // angles in units of 2^32 per turn
    localparam logic [Z_W-1:0] QUARTER_TURN     = 32'h4000_0000;
    localparam logic [Z_W-1:0] NEG_QUARTER_TURN = 32'hC000_0000;
    localparam logic [Z_W-1:0] PHASE_HALF_LSB   =
        {{(Z_W-1){1'b0}}, 1'b1} << (Z_W - 1 - PHASE_BITS);

    localparam logic [Z_W-1:0] ATAN_TAB [ATAN_LEN] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
    };

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] i_sample;
        logic signed [SAMPLE_BITS-1:0] q_sample;
    } t_in_item;

    typedef struct packed {
        logic [POWER_BITS-1:0]       power;
        logic signed [FREQ_BITS-1:0] freq_hz;
    } t_out_item;

    // side data that rides along with the rotation
    typedef struct packed {
        logic [SQ_W-1:0] sq_i;
        logic [SQ_W-1:0] sq_q;
        logic            zero;
    } t_tag;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic [Z_W-1:0]         z;
        t_tag                   tag;
    } t_vec;

endpackage

FILE: src/iqfd_front.sv
// ----------------------------------------------------------------------------
// iqfd_front
// Input register, half-plane fold into the right half plane and the two
// squares for the power.
// ----------------------------------------------------------------------------
module iqfd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  iqfd_pkg::t_in_item i_item,
    output logic              o_valid,
    input  logic              i_ready,
    output iqfd_pkg::t_vec    o_vec
);

    logic               r_a_valid;
    iqfd_pkg::t_in_item r_a_item;
    logic               r_b_valid;
    iqfd_pkg::t_vec     r_b_vec;
    iqfd_pkg::t_vec     n_b_vec;
    logic               a_ready;
    logic               b_ready;

    assign b_ready = !r_b_valid || i_ready;
    assign a_ready = !r_a_valid || b_ready;
    assign o_ready = a_ready;
    assign o_valid = r_b_valid;
    assign o_vec   = r_b_vec;

    always_comb begin
        logic signed [iqfd_pkg::XY_W-1:0] xe;
        logic signed [iqfd_pkg::XY_W-1:0] ye;
        logic signed [iqfd_pkg::SQ_W-1:0] ie;
        logic signed [iqfd_pkg::SQ_W-1:0] qe;
        xe = iqfd_pkg::XY_W'(r_a_item.i_sample) <<< iqfd_pkg::GUARD_BITS;
        ye = iqfd_pkg::XY_W'(r_a_item.q_sample) <<< iqfd_pkg::GUARD_BITS;
        ie = iqfd_pkg::SQ_W'(r_a_item.i_sample);
        qe = iqfd_pkg::SQ_W'(r_a_item.q_sample);
        n_b_vec.tag.sq_i = $unsigned(ie * ie);
        n_b_vec.tag.sq_q = $unsigned(qe * qe);
        n_b_vec.tag.zero = (r_a_item.i_sample == '0) && (r_a_item.q_sample == '0);
        if (xe[iqfd_pkg::XY_W-1] && !ye[iqfd_pkg::XY_W-1]) begin
            // second quadrant: rotate by minus a quarter turn
            n_b_vec.x = ye;
            n_b_vec.y = -xe;
            n_b_vec.z = iqfd_pkg::QUARTER_TURN;
        end else if (xe[iqfd_pkg::XY_W-1]) begin
            n_b_vec.x = -ye;
            n_b_vec.y = xe;
            n_b_vec.z = iqfd_pkg::NEG_QUARTER_TURN;
        end else begin
            n_b_vec.x = xe;
            n_b_vec.y = ye;
            n_b_vec.z = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (a_ready) begin
                r_a_valid <= i_valid;
            end
            if (b_ready) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_ready && i_valid) begin
            r_a_item <= i_item;
        end
        if (b_ready && r_a_valid) begin
            r_b_vec <= n_b_vec;
        end
    end

endmodule

FILE: src/iqfd_cordic.sv
// ----------------------------------------------------------------------------
// iqfd_cordic
// Vectoring CORDIC, a few rotations per register stage, each stage with its
// own valid so bubbles collapse under backpressure.
// ----------------------------------------------------------------------------
module iqfd_cordic (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  iqfd_pkg::t_vec i_vec,
    output logic           o_valid,
    input  logic           i_ready,
    output iqfd_pkg::t_vec o_vec
);

    localparam int NP  = iqfd_pkg::CORDIC_PIPE;
    localparam int IPS = iqfd_pkg::ITERS_PER_STAGE;

    logic           r_valid [NP];
    iqfd_pkg::t_vec r_vec   [NP];
    logic           stage_ready [NP];

    for (genvar s = 0; s < NP; s++) begin : g_stage
        iqfd_pkg::t_vec s_in;
        iqfd_pkg::t_vec n_vec;
        logic           s_in_valid;
        logic           s_dn_ready;

        if (s == 0) begin : g_first
            assign s_in       = i_vec;
            assign s_in_valid = i_valid;
        end else begin : g_mid
            assign s_in       = r_vec[s-1];
            assign s_in_valid = r_valid[s-1];
        end

        if (s == NP - 1) begin : g_last
            assign s_dn_ready = i_ready;
        end else begin : g_next
            assign s_dn_ready = stage_ready[s+1];
        end

        assign stage_ready[s] = !r_valid[s] || s_dn_ready;

        always_comb begin
            logic signed [iqfd_pkg::XY_W-1:0] x;
            logic signed [iqfd_pkg::XY_W-1:0] y;
            logic signed [iqfd_pkg::XY_W-1:0] xs;
            logic signed [iqfd_pkg::XY_W-1:0] ys;
            logic [iqfd_pkg::Z_W-1:0]         z;
            x  = s_in.x;
            y  = s_in.y;
            z  = s_in.z;
            xs = '0;
            ys = '0;
            for (int j = 0; j < IPS; j++) begin
                if (s * IPS + j < iqfd_pkg::ITERS) begin
                    xs = x >>> (s * IPS + j);
                    ys = y >>> (s * IPS + j);
                    if (!y[iqfd_pkg::XY_W-1]) begin
                        x = x + ys;
                        y = y - xs;
                        z = z + iqfd_pkg::ATAN_TAB[s * IPS + j];
                    end else begin
                        x = x - ys;
                        y = y + xs;
                        z = z - iqfd_pkg::ATAN_TAB[s * IPS + j];
                    end
                end
            end
            n_vec   = s_in;
            n_vec.x = x;
            n_vec.y = y;
            n_vec.z = z;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (stage_ready[s]) begin
                r_valid[s] <= s_in_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (stage_ready[s] && s_in_valid) begin
                r_vec[s] <= n_vec;
            end
        end
    end

    assign o_ready = stage_ready[0];
    assign o_valid = r_valid[NP-1];
    assign o_vec   = r_vec[NP-1];

endmodule

FILE: src/iqfd_freq.sv
// ----------------------------------------------------------------------------
// iqfd_freq
// Phase rounding, wrapped phase step against the previous sample, scaling
// by the sample rate and the result register.
// ----------------------------------------------------------------------------
module iqfd_freq (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  iqfd_pkg::t_vec                     i_vec,
    input  logic [iqfd_pkg::RATE_BITS-1:0]     i_rate,
    output logic                               o_valid,
    input  logic                               i_ready,
    output iqfd_pkg::t_out_item                o_item
);

    logic                                     r_r_valid;
    logic signed [iqfd_pkg::PHASE_BITS-1:0]   r_r_diff;
    logic [iqfd_pkg::POWER_BITS-1:0]          r_r_power;
    logic [iqfd_pkg::PHASE_BITS-1:0]          r_last_phase;
    logic                                     r_o_valid;
    iqfd_pkg::t_out_item                      r_o_item;

    logic [iqfd_pkg::Z_W-1:0]                 z_round;
    logic [iqfd_pkg::PHASE_BITS-1:0]          phase;
    logic [iqfd_pkg::SUM_W-1:0]               pw_sum;
    logic [iqfd_pkg::POWER_BITS-1:0]          n_r_power;
    logic signed [iqfd_pkg::PROD_W-1:0]       diff_ext;
    logic signed [iqfd_pkg::PROD_W-1:0]       rate_ext;
    logic signed [iqfd_pkg::PROD_W-1:0]       prod;
    logic                                     r_ready;
    logic                                     o_stage_ready;

    assign o_stage_ready = !r_o_valid || i_ready;
    assign r_ready       = !r_r_valid || o_stage_ready;
    assign o_ready       = r_ready;
    assign o_valid       = r_o_valid;
    assign o_item        = r_o_item;

    // round to nearest phase unit, wrap modulo one turn
    assign z_round = i_vec.z + iqfd_pkg::PHASE_HALF_LSB;
    assign phase   = i_vec.tag.zero ? '0
                   : z_round[iqfd_pkg::Z_W-1 -: iqfd_pkg::PHASE_BITS];

    assign pw_sum    = iqfd_pkg::SUM_W'(i_vec.tag.sq_i) + iqfd_pkg::SUM_W'(i_vec.tag.sq_q);
    assign n_r_power = (|pw_sum[iqfd_pkg::SUM_W-1:iqfd_pkg::POWER_BITS]) ? '1
                     : pw_sum[iqfd_pkg::POWER_BITS-1:0];

    assign diff_ext = iqfd_pkg::PROD_W'(r_r_diff);
    assign rate_ext = $signed(iqfd_pkg::PROD_W'(i_rate));
    assign prod     = diff_ext * rate_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
            r_last_phase <= '0;
        end else begin
            if (r_ready) begin
                r_r_valid <= i_valid;
            end
            if (r_ready && i_valid) begin
                r_last_phase <= phase;
            end
            if (o_stage_ready) begin
                r_o_valid <= r_r_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_ready && i_valid) begin
            r_r_diff  <= $signed(phase - r_last_phase);
            r_r_power <= n_r_power;
        end
        if (o_stage_ready && r_r_valid) begin
            r_o_item.power   <= r_r_power;
            // floor of step * rate / 2^PHASE_BITS
            r_o_item.freq_hz <= prod[iqfd_pkg::PHASE_BITS +: iqfd_pkg::FREQ_BITS];
        end
    end

endmodule

FILE: src/iq_frequency_discriminator_top.sv
// ----------------------------------------------------------------------------
// iq_frequency_discriminator_top
// FM discriminator on complex samples: power and instantaneous frequency.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_stall / i_in_item carries one I/Q sample per
// transfer. Output channel o_out_valid / i_out_stall / o_out_item returns one
// result per sample, in order: the squared magnitude and the frequency in Hz,
// floor(phase step * sample_rate / 2^PHASE_BITS), phase from a CORDIC atan2.
// Configuration: i_cfg_valid / o_cfg_ready / i_cfg_data writes sample_rate;
// o_cfg_ready is always high. Write it only while no sample is in flight.
// Throughput is one sample per clock while i_out_stall is low. The input
// transfer passes through the input register, fold and squares, four CORDIC
// register stages of four rotations each, phase step, scaled result register.
// The only loop-carried state is the previous phase, updated by one subtract
// in the phase step stage, so back to back samples need no spacing.
// Every stage has its own valid, so o_in_stall only rises once all stages
// hold data and i_out_stall is high; a stalled result holds on o_out_item.
// Reset (synchronous, active low) empties the pipeline, clears the previous
// phase to zero and sets sample_rate to 48000.
// ----------------------------------------------------------------------------
module iq_frequency_discriminator_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  iqfd_pkg::t_in_item               i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output iqfd_pkg::t_out_item              o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [iqfd_pkg::RATE_BITS-1:0]   i_cfg_data
);

    logic [iqfd_pkg::RATE_BITS-1:0] r_sample_rate;

    logic           front_ready;
    logic           front_valid;
    iqfd_pkg::t_vec front_vec;
    logic           cordic_ready;
    logic           cordic_valid;
    iqfd_pkg::t_vec cordic_vec;
    logic           freq_ready;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = !front_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate <= iqfd_pkg::RATE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_sample_rate <= i_cfg_data;
        end
    end

    iqfd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (front_ready),
        .i_item  (i_in_item),
        .o_valid (front_valid),
        .i_ready (cordic_ready),
        .o_vec   (front_vec)
    );

    iqfd_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (cordic_ready),
        .i_vec   (front_vec),
        .o_valid (cordic_valid),
        .i_ready (freq_ready),
        .o_vec   (cordic_vec)
    );

    iqfd_freq u_freq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (cordic_valid),
        .o_ready (freq_ready),
        .i_vec   (cordic_vec),
        .i_rate  (r_sample_rate),
        .o_valid (o_out_valid),
        .i_ready (!i_out_stall),
        .o_item  (o_out_item)
    );

    // reset restores the default rate and empties the pipeline
    a_reset_rate: assert property (@(posedge i_clk)
        !i_rst_n |=> r_sample_rate == iqfd_pkg::RATE_RESET)
        else $error("sample rate not restored by reset");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |=> r_sample_rate == $past(i_cfg_data))
        else $error("configuration transfer not taken");

    // input backpressure only when the receiver holds off
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled while the output side is free");

endmodule
